[rtl/core/source_token_lexer_core_macros.svh]
// Assertion macros used by the source token lexer top level.
`ifndef SOURCE_TOKEN_LEXER_CORE_MACROS_SVH
`define SOURCE_TOKEN_LEXER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define STLX_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("lexer check failed");
// Next-cycle implication, checked outside reset.
`define STLX_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("lexer check failed");
`else
`define STLX_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define STLX_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

[rtl/core/stlx_pkg.sv]
// Types, constants and pattern table of the source token lexer.
`default_nettype none
package stlx_pkg;

  localparam int LOOKAHEAD     = 8;
  localparam int SPAN          = 8;
  localparam int LINE_BITS     = 24;
  localparam int POS_BITS      = 32;
  localparam int MAX_RESULTS   = 9;
  localparam int STEP_LIMIT    = 4 * LOOKAHEAD + 16;
  localparam int WIN_BITS      = 8 * LOOKAHEAD;
  localparam int FILL_BITS     = $clog2(LOOKAHEAD + 1);
  localparam int GUARD_BITS    = $clog2(STEP_LIMIT + 1);
  localparam int COUNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int N_PATTERNS    = 50;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  // Token kinds with a meaning of their own.
  localparam logic [5:0] K_INT   = 6'd0;
  localparam logic [5:0] K_BOOL  = 6'd1;
  localparam logic [5:0] K_STR   = 6'd2;
  localparam logic [5:0] K_IDENT = 6'd51;
  localparam logic [5:0] K_END   = 6'd52;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_HEX    = 2'd1;
  localparam logic [1:0] ERR_UNTERM = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_LINE   = 4'd1,
    M_BLOCK  = 4'd2,
    M_HEX    = 4'd3,
    M_HEXBAD = 4'd4,
    M_DEC    = 4'd5,
    M_STR    = 4'd6,
    M_IDENT  = 4'd7,
    M_DONE   = 4'd8
  } scan_mode_t;

  typedef enum logic {
    ENG_WAIT = 1'b0,
    ENG_RUN  = 1'b1
  } eng_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } src_item_t;

  typedef struct packed {
    logic [5:0]           kind;
    logic [LINE_BITS-1:0] line;
    logic [63:0]          value;
    logic                 sign;
    logic [POS_BITS-1:0]  start;
    logic [15:0]          length;
    logic [1:0]           err;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [WIN_BITS-1:0]  text;
    logic [FILL_BITS-1:0] len;
    logic [5:0]           kind;
    logic                 val;
  } pattern_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_dig(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // Left-justifies a pattern so that its first byte lines up with the window head.
  function automatic pattern_t pat(input logic [WIN_BITS-1:0] t, input int unsigned n,
                                   input logic [5:0] k, input logic v);
    pattern_t p;
    p.text = t << (WIN_BITS - 8 * n);
    p.len  = FILL_BITS'(n);
    p.kind = k;
    p.val  = v;
    return p;
  endfunction

  // Keyword and operator table in priority order.
  function automatic pattern_t pattern_entry(input logic [5:0] idx);
    pattern_t p;
    unique case (idx)
      6'd0:  p = pat(WIN_BITS'("true"), 4, 6'd1, 1'b1);
      6'd1:  p = pat(WIN_BITS'("false"), 5, 6'd1, 1'b0);
      6'd2:  p = pat(WIN_BITS'("let"), 3, 6'd3, 1'b0);
      6'd3:  p = pat(WIN_BITS'("cast"), 4, 6'd4, 1'b0);
      6'd4:  p = pat(WIN_BITS'("sizeof"), 6, 6'd5, 1'b0);
      6'd5:  p = pat(WIN_BITS'("extern"), 6, 6'd6, 1'b0);
      6'd6:  p = pat(WIN_BITS'("if"), 2, 6'd7, 1'b0);
      6'd7:  p = pat(WIN_BITS'("else"), 4, 6'd8, 1'b0);
      6'd8:  p = pat(WIN_BITS'("while"), 5, 6'd9, 1'b0);
      6'd9:  p = pat(WIN_BITS'("break"), 5, 6'd10, 1'b0);
      6'd10: p = pat(WIN_BITS'("continue"), 8, 6'd11, 1'b0);
      6'd11: p = pat(WIN_BITS'("func"), 4, 6'd12, 1'b0);
      6'd12: p = pat(WIN_BITS'("return"), 6, 6'd13, 1'b0);
      6'd13: p = pat(WIN_BITS'("struct"), 6, 6'd14, 1'b0);
      6'd14: p = pat(WIN_BITS'("<<"), 2, 6'd15, 1'b0);
      6'd15: p = pat(WIN_BITS'(">>"), 2, 6'd16, 1'b0);
      6'd16: p = pat(WIN_BITS'("<="), 2, 6'd17, 1'b0);
      6'd17: p = pat(WIN_BITS'(">="), 2, 6'd18, 1'b0);
      6'd18: p = pat(WIN_BITS'("<"), 1, 6'd19, 1'b0);
      6'd19: p = pat(WIN_BITS'(">"), 1, 6'd20, 1'b0);
      6'd20: p = pat(WIN_BITS'("&&"), 2, 6'd21, 1'b0);
      6'd21: p = pat(WIN_BITS'("||"), 2, 6'd22, 1'b0);
      6'd22: p = pat(WIN_BITS'("=="), 2, 6'd23, 1'b0);
      6'd23: p = pat(WIN_BITS'("!="), 2, 6'd24, 1'b0);
      6'd24: p = pat(WIN_BITS'("++"), 2, 6'd25, 1'b0);
      6'd25: p = pat(WIN_BITS'("--"), 2, 6'd26, 1'b0);
      6'd26: p = pat(WIN_BITS'("+="), 2, 6'd27, 1'b0);
      6'd27: p = pat(WIN_BITS'("-="), 2, 6'd28, 1'b0);
      6'd28: p = pat(WIN_BITS'("*="), 2, 6'd29, 1'b0);
      6'd29: p = pat(WIN_BITS'("/="), 2, 6'd30, 1'b0);
      6'd30: p = pat(WIN_BITS'("->"), 2, 6'd31, 1'b0);
      6'd31: p = pat(WIN_BITS'("."), 1, 6'd32, 1'b0);
      6'd32: p = pat(WIN_BITS'("("), 1, 6'd33, 1'b0);
      6'd33: p = pat(WIN_BITS'(")"), 1, 6'd34, 1'b0);
      6'd34: p = pat(WIN_BITS'("{"), 1, 6'd35, 1'b0);
      6'd35: p = pat(WIN_BITS'("}"), 1, 6'd36, 1'b0);
      6'd36: p = pat(WIN_BITS'("+"), 1, 6'd37, 1'b0);
      6'd37: p = pat(WIN_BITS'("-"), 1, 6'd38, 1'b0);
      6'd38: p = pat(WIN_BITS'("*"), 1, 6'd39, 1'b0);
      6'd39: p = pat(WIN_BITS'("/"), 1, 6'd40, 1'b0);
      6'd40: p = pat(WIN_BITS'("%"), 1, 6'd41, 1'b0);
      6'd41: p = pat(WIN_BITS'("!"), 1, 6'd42, 1'b0);
      6'd42: p = pat(WIN_BITS'("&"), 1, 6'd43, 1'b0);
      6'd43: p = pat(WIN_BITS'("|"), 1, 6'd44, 1'b0);
      6'd44: p = pat(WIN_BITS'("^"), 1, 6'd45, 1'b0);
      6'd45: p = pat(WIN_BITS'("~"), 1, 6'd46, 1'b0);
      6'd46: p = pat(WIN_BITS'("="), 1, 6'd47, 1'b0);
      6'd47: p = pat(WIN_BITS'(","), 1, 6'd48, 1'b0);
      6'd48: p = pat(WIN_BITS'(":"), 1, 6'd49, 1'b0);
      6'd49: p = pat(WIN_BITS'(";"), 1, 6'd50, 1'b0);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[rtl/core/source_token_lexer_core.sv]
// Top level of the streaming source token lexer.
//
// Source bytes enter through a queue port: a transaction completes when push is
// high and full is low. Tokens leave through a second queue port: the oldest
// token is on the result ports while empty is low and is taken when pop is high.
// Each token carries kind, line, value, sign, text offset and length, an error
// code, and last_of_run on the final token caused by one input byte.
// A four-entry intake queue feeds the scanner engine, which runs one scan step
// per cycle while the result queue is not full, on an eight-byte lookahead window;
// a four-entry result queue drains it. A byte that only fills the window causes
// no scan step, and a byte that continues a literal, identifier, string or comment
// causes one. A byte with end_of_source set flushes the window.
// The first token of a byte passes through the intake queue, the engine's held
// result register and the result queue before it reaches the result ports.
// The synchronous reset empties both queues and returns the scanner to line one,
// offset zero. When the receiver stops popping, the result queue fills, the
// engine holds, and full rises once the intake queue is also full.
`default_nettype none
`include "source_token_lexer_core_macros.svh"
module source_token_lexer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        end_of_source,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  token_kind,
  output logic [23:0] line_number,
  output logic [63:0] token_value,
  output logic        negative_sign,
  output logic [31:0] text_start,
  output logic [15:0] text_length,
  output logic [1:0]  error_code,
  output logic        last_of_run
);
  import stlx_pkg::*;

  logic      in_valid;
  src_item_t in_item;
  logic      in_pop;
  logic      res_full;
  logic      res_push;
  result_t   res_item;
  result_t   head;

  // Front: byte intake.
  stlx_intake u_intake (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .char_byte     (char_byte),
    .end_of_source (end_of_source),
    .item_valid    (in_valid),
    .item          (in_item),
    .item_pop      (in_pop)
  );

  // Back: scanner.
  stlx_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_pop   (in_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  // Output queue.
  stlx_result_queue u_results (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_item (res_item),
    .full    (res_full),
    .empty   (empty),
    .pop     (pop),
    .rd_item (head)
  );

  // Result fields.
  assign token_kind    = head.kind;
  assign line_number   = head.line;
  assign token_value   = head.value;
  assign negative_sign = head.sign;
  assign text_start    = head.start;
  assign text_length   = head.length;
  assign error_code    = head.err;
  assign last_of_run   = head.last;

  // Checks on the engine hand-offs and result contents.
  `STLX_ASSERT_IMPLY(a_no_push_full, clk, rst, res_push, !res_full)
  `STLX_ASSERT_IMPLY(a_no_pop_empty, clk, rst, in_pop, in_valid)
  `STLX_ASSERT_IMPLY(a_line_nonzero, clk, rst, !empty, line_number != 24'd0)

endmodule
`default_nettype wire

[rtl/core/stlx_intake.sv]
// Front queue that takes source bytes and holds them for the lexer engine.
`default_nettype none
module stlx_intake (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          char_byte,
  input  logic                end_of_source,
  output logic                item_valid,
  output stlx_pkg::src_item_t item,
  input  logic                item_pop
);
  import stlx_pkg::*;

  src_item_t             slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;
  logic                  do_push;
  logic                  do_pop;

  // Handshake qualifiers.
  assign full       = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign item_valid = (count != '0);
  assign item       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  // Storage, written only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{data: char_byte, fin: end_of_source};
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end
  end

endmodule
`default_nettype wire

[rtl/core/stlx_engine.sv]
// Back end: lookahead window and scanner that turns bytes into token results.
`default_nettype none
module stlx_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  stlx_pkg::src_item_t in_item,
  output logic                in_pop,
  input  logic                res_full,
  output logic                res_push,
  output stlx_pkg::result_t   res_item
);
  import stlx_pkg::*;

  // Step control.
  eng_state_t             eng_state;
  logic                   fin_r;
  logic [COUNT_BITS-1:0]  n_cnt;
  logic [GUARD_BITS-1:0]  guard;
  logic                   pend_v;
  result_t                pend;

  // Lexer state.
  scan_mode_t             mode;
  logic [WIN_BITS-1:0]    win;
  logic [FILL_BITS-1:0]   fill;
  logic [LINE_BITS-1:0]   line;
  logic [POS_BITS-1:0]    pos;
  logic [63:0]            acc;
  logic                   minus;
  logic [POS_BITS-1:0]    tbegin;

  // Next values from one scan step.
  scan_mode_t             mode_next;
  logic [WIN_BITS-1:0]    win_next;
  logic [FILL_BITS-1:0]   fill_next;
  logic [LINE_BITS-1:0]   line_next;
  logic [POS_BITS-1:0]    pos_next;
  logic [63:0]            acc_next;
  logic                   minus_next;
  logic [POS_BITS-1:0]    tbegin_next;
  logic                   a_cont;
  logic                   a_emit;
  result_t                a_res;

  logic                   pm_hit;
  pattern_t               pm;
  logic                   stop;
  logic                   stall;
  logic [WIN_BITS-1:0]    win_load;
  logic                   can_load;

  // Priority match of the window head against the keyword and operator table.
  always_comb begin
    pattern_t            e;
    logic [WIN_BITS-1:0] m;
    pm_hit = 1'b0;
    pm     = '0;
    for (int i = N_PATTERNS - 1; i >= 0; i--) begin
      e = pattern_entry(6'(i));
      m = ~({WIN_BITS{1'b1}} >> (8 * e.len));
      if ((win & m) == e.text) begin
        pm_hit = 1'b1;
        pm     = e;
      end
    end
  end

  // One scan step on the current window.
  always_comb begin
    logic [7:0]           h;
    logic [7:0]           c1;
    logic [7:0]           c2;
    logic [FILL_BITS-1:0] tk;
    logic [FILL_BITS-1:0] k;
    logic                 do_fin;
    logic [1:0]           fin_err;
    logic [LINE_BITS-1:0] line_inc;
    logic [63:0]          d;
    logic [POS_BITS-1:0]  diff;
    logic [15:0]          tlen;
    logic                 win_full;

    h        = win[WIN_BITS-1 -: 8];
    c1       = win[WIN_BITS-9 -: 8];
    c2       = win[WIN_BITS-17 -: 8];
    win_full = (fill >= FILL_BITS'(SPAN));
    line_inc = (line != {LINE_BITS{1'b1}}) ? line + 1'b1 : line;
    diff     = pos - tbegin;
    tlen     = (diff > POS_BITS'(16'hFFFF)) ? 16'hFFFF : diff[15:0];
    d        = '0;
    tk       = '0;
    do_fin   = 1'b0;
    fin_err  = ERR_NONE;

    a_cont      = 1'b0;
    a_emit      = 1'b0;
    a_res       = '0;
    a_res.line  = line;
    mode_next   = mode;
    line_next   = line;
    acc_next    = acc;
    minus_next  = minus;
    tbegin_next = tbegin;

    if (mode == M_DONE || n_cnt >= COUNT_BITS'(MAX_RESULTS)) begin
      a_cont = 1'b0;
    end else if (mode == M_IDLE) begin
      if (fill == '0 && !fin_r) begin
        a_cont = 1'b0;
      end else if (h == 8'd0) begin
        do_fin = 1'b1;
      end else if (!win_full && !fin_r) begin
        a_cont = 1'b0;
      end else begin
        a_cont = 1'b1;
        if (h == " " || h == 8'h09 || h == 8'h0D || h == 8'h0A) begin
          if (h == 8'h0A) line_next = line_inc;
          tk = FILL_BITS'(1);
        end else if (h == "/" && c1 == "/") begin
          tk        = FILL_BITS'(2);
          mode_next = M_LINE;
        end else if (h == "/" && c1 == "*") begin
          tk        = FILL_BITS'(2);
          mode_next = M_BLOCK;
        end else if (h == "0" && c1 == "x") begin
          tk        = FILL_BITS'(2);
          acc_next  = '0;
          mode_next = M_HEX;
        end else if (is_dig(h)) begin
          acc_next   = '0;
          minus_next = 1'b0;
          mode_next  = M_DEC;
        end else if ((h == "+" || h == "-") && is_dig(c1)) begin
          acc_next   = '0;
          minus_next = (h == "-");
          tk         = FILL_BITS'(1);
          mode_next  = M_DEC;
        end else if (h == "\"") begin
          tk          = FILL_BITS'(1);
          tbegin_next = pos + POS_BITS'(1);
          mode_next   = M_STR;
        end else if (h == "'") begin
          if (c1 == 8'd0 || c2 == 8'd0) begin
            do_fin  = 1'b1;
            fin_err = ERR_UNTERM;
          end else begin
            a_emit      = 1'b1;
            a_res.kind  = K_INT;
            a_res.value = {56'd0, c1};
            tk          = FILL_BITS'(3);
          end
        end else if (pm_hit) begin
          a_emit      = 1'b1;
          a_res.kind  = pm.kind;
          a_res.value = {63'd0, pm.val};
          tk          = pm.len;
        end else begin
          tbegin_next = pos;
          tk          = FILL_BITS'(1);
          mode_next   = M_IDENT;
        end
      end
    end else if (fill == '0 && !fin_r) begin
      a_cont = 1'b0;
    end else begin
      a_cont = 1'b1;
      unique case (mode) inside
        M_LINE: begin
          if (h == 8'd0 || h == 8'h0D || h == 8'h0A) mode_next = M_IDLE;
          else tk = FILL_BITS'(1);
        end
        M_BLOCK: begin
          if (fill < FILL_BITS'(2) && !fin_r) begin
            a_cont = 1'b0;
          end else if (h == 8'd0) begin
            do_fin  = 1'b1;
            fin_err = ERR_UNTERM;
          end else if (h == "*" && c1 == "/") begin
            tk        = FILL_BITS'(2);
            mode_next = M_IDLE;
          end else begin
            if (h == 8'h0A) line_next = line_inc;
            tk = FILL_BITS'(1);
          end
        end
        M_HEX, M_HEXBAD: begin
          if (is_alnum(h)) begin
            if (is_dig(h)) d = {60'd0, h[3:0]};
            else if (h >= "a" && h <= "f") d = 64'(h - "a" + 8'd10);
            else if (h >= "A" && h <= "F") d = 64'(h - "A" + 8'd10);
            else mode_next = M_HEXBAD;
            acc_next = {acc[59:0], 4'd0} + d;
            tk       = FILL_BITS'(1);
          end else begin
            a_emit      = 1'b1;
            a_res.kind  = K_INT;
            a_res.value = acc;
            a_res.err   = (mode == M_HEXBAD) ? ERR_HEX : ERR_NONE;
            mode_next   = M_IDLE;
          end
        end
        M_DEC: begin
          if (is_dig(h)) begin
            acc_next = {acc[60:0], 3'd0} + {acc[62:0], 1'b0} + {60'd0, h[3:0]};
            tk       = FILL_BITS'(1);
          end else begin
            a_emit      = 1'b1;
            a_res.kind  = K_INT;
            a_res.value = minus ? (64'd0 - acc) : acc;
            a_res.sign  = minus;
            mode_next   = M_IDLE;
          end
        end
        M_STR: begin
          if (h == 8'd0) begin
            do_fin  = 1'b1;
            fin_err = ERR_UNTERM;
          end else begin
            if (h == "\"") begin
              a_emit       = 1'b1;
              a_res.kind   = K_STR;
              a_res.start  = tbegin;
              a_res.length = tlen;
              mode_next    = M_IDLE;
            end
            tk = FILL_BITS'(1);
          end
        end
        M_IDENT: begin
          if (is_alnum(h) || h == "_") begin
            tk = FILL_BITS'(1);
          end else begin
            a_emit       = 1'b1;
            a_res.kind   = K_IDENT;
            a_res.start  = tbegin;
            a_res.length = tlen;
            mode_next    = M_IDLE;
          end
        end
        default: mode_next = M_IDLE;
      endcase
    end

    // End of source: end token, window flushed, scanner parked.
    if (do_fin) begin
      a_cont     = 1'b1;
      a_emit     = 1'b1;
      a_res      = '0;
      a_res.line = line;
      a_res.kind = K_END;
      a_res.err  = fin_err;
      mode_next  = M_DONE;
    end

    // Consume bytes from the window head.
    k         = (tk > fill) ? fill : tk;
    win_next  = do_fin ? '0 : (win << {k, 3'b000});
    fill_next = do_fin ? '0 : fill - k;
    pos_next  = pos + POS_BITS'(k);
  end

  // A new byte lands at the first free slot of the window.
  assign can_load = (mode != M_DONE) && (fill < FILL_BITS'(LOOKAHEAD));
  assign win_load = can_load ? (win | ({in_item.data, {(WIN_BITS-8){1'b0}}} >> {fill, 3'b000}))
                             : win;

  // Step sequencing and output hand-off.
  assign stall    = res_full;
  assign stop     = (guard == GUARD_BITS'(STEP_LIMIT)) || !a_cont;
  assign in_pop   = !stall && in_valid && ((eng_state == ENG_WAIT) || (stop && !fin_r));
  assign res_push = !stall && (eng_state == ENG_RUN) && pend_v && (stop || a_emit);

  always_comb begin
    res_item      = pend;
    res_item.last = stop;
  end

  // Held result payload.
  always_ff @(posedge clk) begin
    if (!stall && eng_state == ENG_RUN && !stop && a_emit) begin
      pend <= a_res;
    end
  end

  // Control and lexer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      eng_state <= ENG_WAIT;
      fin_r     <= 1'b0;
      n_cnt     <= '0;
      guard     <= '0;
      pend_v    <= 1'b0;
      mode      <= M_IDLE;
      win       <= '0;
      fill      <= '0;
      line      <= LINE_BITS'(1);
      pos       <= '0;
      acc       <= '0;
      minus     <= 1'b0;
      tbegin    <= '0;
    end else if (!stall) begin
      if (eng_state == ENG_RUN && !stop) begin
        mode   <= mode_next;
        win    <= win_next;
        fill   <= fill_next;
        line   <= line_next;
        pos    <= pos_next;
        acc    <= acc_next;
        minus  <= minus_next;
        tbegin <= tbegin_next;
        guard  <= guard + 1'b1;
        n_cnt  <= n_cnt + COUNT_BITS'(a_emit);
        if (a_emit) pend_v <= 1'b1;
      end else begin
        if (eng_state == ENG_RUN) pend_v <= 1'b0;
        if (eng_state == ENG_RUN && fin_r) begin
          eng_state <= ENG_WAIT;
          fin_r     <= 1'b0;
          mode      <= M_IDLE;
          win       <= '0;
          fill      <= '0;
          line      <= LINE_BITS'(1);
          pos       <= '0;
          acc       <= '0;
          minus     <= 1'b0;
          tbegin    <= '0;
        end else if (in_valid) begin
          win       <= win_load;
          fill      <= can_load ? fill + 1'b1 : fill;
          fin_r     <= in_item.fin;
          n_cnt     <= '0;
          guard     <= '0;
          eng_state <= ENG_RUN;
        end else begin
          eng_state <= ENG_WAIT;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/stlx_result_queue.sv]
// Result queue between the lexer engine and the output ports.
`default_nettype none
module stlx_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  stlx_pkg::result_t wr_item,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output stlx_pkg::result_t rd_item
);
  import stlx_pkg::*;

  result_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;
  logic                  do_wr;
  logic                  do_rd;

  // Occupancy flags and head entry.
  assign full    = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = slots[rd_ptr];
  assign do_wr   = wr && !full;
  assign do_rd   = pop && !empty;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_BITS'(do_wr) - QCNT_BITS'(do_rd);
    end
  end

endmodule
`default_nettype wire
